@@ hdl/fdmc_pkg.sv @@
`timescale 1ns / 1ps
package fdmc_pkg;
    localparam int DEPTH = 64;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_POP   = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_COUNT = 3'd3;
    localparam logic [2:0] OP_MODE  = 3'd4;
    localparam logic [2:0] OP_CLEAR = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [6:0]  tally;
        logic [1:0]  status;
        logic [6:0]  occupancy;
    } out_item_t;
endpackage

@@ hdl/fdmc_if.sv @@
`timescale 1ns / 1ps
interface fdmc_in_if;
    logic valid;
    logic ready;
    logic [2:0] opcode;
    logic signed [31:0] value;
    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);
endinterface

interface fdmc_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] read_value;
    logic [6:0] tally;
    logic [1:0] status;
    logic [6:0] occupancy;
    modport source (output valid, output read_value, output tally, output status,
                    output occupancy, input ready);
    modport sink (input valid, input read_value, input tally, input status,
                  input occupancy, output ready);
endinterface

@@ hdl/fifo_with_dedupe_and_mode_count.sv @@
`timescale 1ns / 1ps
// Push, clear, unused opcodes, and pop or peek on an empty queue go straight to S_DONE
// after the input transfer; pop and peek otherwise pass through S_RD and S_PEEKD first.
// Count-and-dedupe and mode-and-dedupe copy the N held entries to scratch, then scan
// them (mode compares each entry against the others), using one shared 32-bit compare
// unit and one read and one write port per memory, stepped by a sequencer. One item at
// a time: the next input transfer can happen the cycle after the result transfer.
// Reset (async, rst_n low) empties the queue; the ring contents are not cleared.
module fifo_with_dedupe_and_mode_count
(
    input logic clk,
    input logic rst_n,
    fdmc_in_if.sink in_ch,
    fdmc_out_if.source out_ch
);
    localparam int AW = fdmc_pkg::AW;
    localparam int CW = fdmc_pkg::CW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;  // read issued, wait data
    localparam logic [3:0] S_PEEKD = 4'd2;
    localparam logic [3:0] S_CPY   = 4'd3;  // copy ring to scratch
    localparam logic [3:0] S_CPYW  = 4'd4;
    localparam logic [3:0] S_IRD   = 4'd5;  // read scratch[i]
    localparam logic [3:0] S_IW    = 4'd6;
    localparam logic [3:0] S_JRD   = 4'd7;  // read scratch[j]
    localparam logic [3:0] S_JW    = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [31:0] ring [fdmc_pkg::DEPTH];
    logic [31:0] scr  [fdmc_pkg::DEPTH];
    logic [31:0] ring_q_reg, scr_q_reg;

    logic [3:0]  state_reg;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] fill_reg, n_reg, i_reg, j_reg, kept_reg, mult_reg, best_reg, hits_reg;
    logic [2:0]  op_reg;
    logic [31:0] key_reg, w_reg;
    logic        seen_reg;
    logic        ovalid_reg;
    fdmc_pkg::out_item_t res_reg;

    logic        eq;
    assign eq = (scr_q_reg == (op_reg == fdmc_pkg::OP_COUNT ? key_reg : w_reg));

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] o);
        return h + o[AW-1:0];
    endfunction

    assign in_ch.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.read_value = res_reg.read_value;
    assign out_ch.tally = res_reg.tally;
    assign out_ch.status = res_reg.status;
    assign out_ch.occupancy = res_reg.occupancy;

    logic acc;
    assign acc = in_ch.valid && in_ch.ready;

    // memory ports
    logic        rwe, swe;
    logic [AW-1:0] rwa, rra, swa, sra;
    logic [31:0] rwd, swd;
    logic        keep_w;

    always_comb
    begin
        rwe = 1'b0; rwa = slot(head_reg, fill_reg); rwd = in_ch.value;
        swe = 1'b0; swa = i_reg[AW-1:0]; swd = ring_q_reg;
        rra = slot(head_reg, i_reg); sra = i_reg[AW-1:0];
        if (acc && in_ch.opcode == fdmc_pkg::OP_PUSH
            && fill_reg != CW'(fdmc_pkg::DEPTH))
            rwe = 1'b1;
        if (state_reg == S_CPYW)
        begin
            swe = 1'b1;
            swa = j_reg[AW-1:0];
        end
        if (state_reg == S_JRD || state_reg == S_JW)
            sra = j_reg[AW-1:0];
        if (state_reg == S_RD || state_reg == S_PEEKD)
            rra = head_reg;
        if (keep_w)
        begin
            rwe = 1'b1;
            rwa = slot(head_reg, kept_reg);
            // count keeps the word being examined, mode the one held in w_reg
            rwd = (state_reg == S_IW) ? scr_q_reg : w_reg;
        end
    end

    always_comb
    begin
        keep_w = 1'b0;
        if (state_reg == S_IW && op_reg == fdmc_pkg::OP_COUNT)
            keep_w = !(eq && hits_reg != '0);
        if (state_reg == S_JRD && op_reg == fdmc_pkg::OP_MODE && j_reg == n_reg && !seen_reg)
            keep_w = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (rwe)
            ring[rwa] <= rwd;
        ring_q_reg <= ring[rra];
        if (swe)
            scr[swa] <= swd;
        scr_q_reg <= scr[sra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg <= '0;
            fill_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        op_reg <= in_ch.opcode;
                        key_reg <= in_ch.value;
                        res_reg <= '0;
                        n_reg <= fill_reg;
                        i_reg <= '0;
                        j_reg <= '0;
                        kept_reg <= '0;
                        hits_reg <= '0;
                        best_reg <= '0;
                        unique case (in_ch.opcode)
                            fdmc_pkg::OP_PUSH:
                            begin
                                if (fill_reg == CW'(fdmc_pkg::DEPTH))
                                    res_reg.status <= fdmc_pkg::ST_FULL;
                                else
                                    fill_reg <= fill_reg + 1'b1;
                                state_reg <= S_DONE;
                            end
                            fdmc_pkg::OP_POP, fdmc_pkg::OP_PEEK:
                            begin
                                if (fill_reg == '0)
                                begin
                                    res_reg.read_value <= -32'sd1;
                                    res_reg.status <= fdmc_pkg::ST_EMPTY;
                                    state_reg <= S_DONE;
                                end
                                else
                                    state_reg <= S_RD;
                            end
                            fdmc_pkg::OP_COUNT, fdmc_pkg::OP_MODE:
                                state_reg <= S_CPY;
                            fdmc_pkg::OP_CLEAR:
                            begin
                                fill_reg <= '0;
                                head_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            default:
                                state_reg <= S_DONE;
                        endcase
                    end
                end
                S_RD:
                    state_reg <= S_PEEKD;
                S_PEEKD:
                begin
                    res_reg.read_value <= ring_q_reg;
                    if (op_reg == fdmc_pkg::OP_POP)
                    begin
                        head_reg <= head_reg + 1'b1;
                        fill_reg <= fill_reg - 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_CPY:
                begin
                    // i drives read address, j trails for write
                    if (i_reg == n_reg)
                    begin
                        i_reg <= '0;
                        state_reg <= S_IRD;
                    end
                    else
                    begin
                        j_reg <= i_reg;
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_CPYW;
                    end
                end
                S_CPYW:
                    state_reg <= S_CPY;
                S_IRD:
                begin
                    if (i_reg == n_reg)
                    begin
                        fill_reg <= kept_reg;
                        res_reg.tally <= (op_reg == fdmc_pkg::OP_COUNT) ? 7'(hits_reg)
                                                                       : 7'(best_reg);
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_IW;
                end
                S_IW:
                begin
                    w_reg <= scr_q_reg;
                    if (op_reg == fdmc_pkg::OP_COUNT)
                    begin
                        if (eq)
                            hits_reg <= hits_reg + 1'b1;
                        if (keep_w)
                            kept_reg <= kept_reg + 1'b1;
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_IRD;
                    end
                    else
                    begin
                        j_reg <= '0;
                        seen_reg <= 1'b0;
                        mult_reg <= '0;
                        state_reg <= S_JRD;
                    end
                end
                S_JRD:
                begin
                    if (j_reg == n_reg || seen_reg)
                    begin
                        if (!seen_reg)
                        begin
                            kept_reg <= kept_reg + 1'b1;
                            if (mult_reg > best_reg)
                                best_reg <= mult_reg;
                        end
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_IRD;
                    end
                    else
                        state_reg <= S_JW;
                end
                S_JW:
                begin
                    if (eq)
                    begin
                        if (j_reg < i_reg)
                            seen_reg <= 1'b1;
                        else
                            mult_reg <= mult_reg + 1'b1;
                    end
                    j_reg <= j_reg + 1'b1;
                    state_reg <= S_JRD;
                end
                S_DONE:
                begin
                    res_reg.occupancy <= 7'(fill_reg);
                    ovalid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= CW'(fdmc_pkg::DEPTH))
        else $error("fill exceeds depth");
    assert property (@(posedge clk) disable iff (!rst_n) ovalid_reg |-> state_reg == S_IDLE)
        else $error("result pending while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IRD && i_reg == n_reg) |=> fill_reg <= $past(n_reg))
        else $error("dedupe grew queue");
endmodule
